// ===== rtl/core/fgjs_pkg.sv =====
// Package for the fixed-gain joint state filter: payload structs, configuration
// layout, register indexes and arithmetic widths. No dependencies.
package fgjs_pkg;

  localparam int STATE_W   = 32;  // Q16.16 state and measurement
  localparam int COEF_W    = 16;  // Q2.14 coefficients
  localparam int MAX_ORDER = 4;   // coefficient slots per configuration word
  localparam int JOINT_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam int JOINTS_DEF = 8;
  localparam int ORDER_DEF  = 4;

  // Q2.14 x Q16.16 products, and sum of up to MAX_ORDER + 1 of them
  localparam int PROD_W   = COEF_W + STATE_W;
  localparam int ACC_W    = PROD_W + 3;
  localparam int ROUND_SH = 14;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd4;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_INIT   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                       operation;
    logic [JOINT_W-1:0]        joint_index;
    logic signed [STATE_W-1:0] measurement;
  } item_t;

  typedef struct packed {
    logic [JOINT_W-1:0]        joint_out;
    logic signed [STATE_W-1:0] position;
    logic signed [STATE_W-1:0] velocity;
  } result_t;

  // Row r, column c of the time matrix lives at a[r][c]; bit layout matches the
  // register words (column 0 in the low bits).
  typedef struct packed {
    logic [MAX_ORDER-1:0][MAX_ORDER-1:0][COEF_W-1:0] a;
    logic [MAX_ORDER-1:0][COEF_W-1:0]                l;
  } cfg_t;

endpackage

// ===== rtl/core/fixed_gain_joint_state_filter_top.sv =====
// Top level of the fixed-gain joint state filter: handshakes, item pipeline,
// same-joint interlock. Depends on fgjs_pkg, fgjs_cfg_regs, fgjs_state_mem,
// fgjs_update_pipe.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  item     | item_valid, item_stall, item_data         | in
//  result   | result_valid, result_stall, result_data   | out
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One item per cycle for items on different joints while the result is not
// stalled; the state is read at the accepting edge, then multiply, accumulate
// and the output register follow.
// An update to a joint with an update or initialize still in the multiply or
// accumulate stage waits, as the read-modify-write loop through the state
// memory must reach that older item's state write.
// Reset clears configuration and the per-joint valid bits; item_stall is high
// and cfg_ready low while rst is high.
// A stalled result freezes the whole pipeline; item_stall follows.
module fixed_gain_joint_state_filter_top
  import fgjs_pkg::*;
#(
  parameter int JOINTS = JOINTS_DEF,
  parameter int ORDER  = ORDER_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item_data,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  typedef struct packed {
    op_e                op;
    logic [JOINT_W-1:0] joint;
  } tag_t;

  cfg_t                          cfg;
  logic                          adv;
  logic                          hazard;
  logic                          accept;
  logic                          s1_v, s2_v, s3_v;
  tag_t                          s1_tag, s2_tag, s3_tag;
  logic signed [STATE_W-1:0]     s1_y;
  logic [ORDER-1:0][STATE_W-1:0] x_row;
  logic [ORDER-1:0][STATE_W-1:0] nx_row;
  logic                          s3_in_range;
  logic                          wr_en;

  assign cfg_ready = !rst;

  fgjs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign adv = !result_valid || !result_stall;

  // an update needs the final state of any older item on its joint
  assign hazard = (item_data.operation == OP_UPDATE) &&
                  ((s1_v && s1_tag.joint == item_data.joint_index) ||
                   (s2_v && s2_tag.joint == item_data.joint_index));

  assign item_stall = rst || !adv || hazard;
  assign accept     = item_valid && !item_stall;

  assign s3_in_range = (int'(s3_tag.joint) < JOINTS);
  assign wr_en       = adv && s3_v && s3_in_range;

  fgjs_state_mem #(
    .DEPTH (JOINTS),
    .ORDER (ORDER),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (AW'(item_data.joint_index)),
    .rd_row  (x_row),
    .wr_en   (wr_en),
    .wr_addr (AW'(s3_tag.joint)),
    .wr_row  (nx_row)
  );

  fgjs_update_pipe #(
    .ORDER (ORDER)
  ) u_pipe (
    .clk (clk),
    .en  (adv),
    .x   (x_row),
    .op  (s1_tag.op),
    .y   (s1_y),
    .cfg (cfg),
    .nx  (nx_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_v         <= accept;
      s2_v         <= s1_v;
      s3_v         <= s2_v;
      result_valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag <= '{op: item_data.operation, joint: item_data.joint_index};
      s1_y   <= item_data.measurement;
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
      result_data.joint_out <= s3_tag.joint;
      result_data.position  <= s3_in_range ? $signed(nx_row[0]) : '0;
      result_data.velocity  <= s3_in_range ? $signed(nx_row[1]) : '0;
    end
  end

`ifndef SYNTHESIS
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && int'(result_data.joint_out) >= JOINTS |->
      result_data.position == '0 && result_data.velocity == '0)
    else $error("out-of-range joint returned nonzero state");

  a_no_raw_s1_s2: assert property (@(posedge clk) disable iff (rst)
    s1_v && s2_v && s1_tag.op == OP_UPDATE |-> s1_tag.joint != s2_tag.joint)
    else $error("update read a joint still in the multiply stage");

  a_no_raw_s2_s3: assert property (@(posedge clk) disable iff (rst)
    s2_v && s3_v && s2_tag.op == OP_UPDATE |-> s2_tag.joint != s3_tag.joint)
    else $error("update used a joint still in the accumulate stage");

  a_write_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !wr_en && !accept)
    else $error("state written or item taken while result transaction stalled");
`endif

endmodule

// ===== rtl/core/fgjs_cfg_regs.sv =====
// Configuration register file: time matrix rows and gain vector.
// Depends on fgjs_pkg.
module fgjs_cfg_regs
  import fgjs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ROW_0: cfg.a[0] <= wr_data;
        REG_ROW_1: cfg.a[1] <= wr_data;
        REG_ROW_2: cfg.a[2] <= wr_data;
        REG_ROW_3: cfg.a[3] <= wr_data;
        REG_GAIN:  cfg.l    <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/fgjs_state_mem.sv =====
// Per-joint state memory: one row of ORDER Q16.16 words per joint, registered
// read with write-first forwarding, per-row valid bits. Depends on fgjs_pkg.
module fgjs_state_mem
  import fgjs_pkg::*;
#(
  parameter int DEPTH = JOINTS_DEF,
  parameter int ORDER = ORDER_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             rd_en,
  input  logic [AW-1:0]                    rd_addr,
  output logic [ORDER-1:0][STATE_W-1:0]    rd_row,
  input  logic                             wr_en,
  input  logic [AW-1:0]                    wr_addr,
  input  logic [ORDER-1:0][STATE_W-1:0]    wr_row
);

  logic [ORDER-1:0][STATE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]              vld;
  logic [ORDER-1:0][STATE_W-1:0] rd_row_q;
  logic                          rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // same-edge write to the addressed row wins over the array contents
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_row_q <= wr_row;
      end else begin
        rd_row_q <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= (wr_en && wr_addr == rd_addr) ? 1'b1 : vld[rd_addr];
      end
    end
  end

  // rows never written since reset read as zero
  assign rd_row = rd_vld ? rd_row_q : '0;

endmodule

// ===== rtl/core/fgjs_update_pipe.sv =====
// Update datapath: multiply stage, accumulate stage, then round/saturate to the
// new state row (or the initialize row). Depends on fgjs_pkg.
module fgjs_update_pipe
  import fgjs_pkg::*;
#(
  parameter int ORDER = ORDER_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ORDER-1:0][STATE_W-1:0] x,
  input  op_e                           op,
  input  logic signed [STATE_W-1:0]     y,
  input  cfg_t                          cfg,
  output logic [ORDER-1:0][STATE_W-1:0] nx
);

  localparam int SH_W = ACC_W - ROUND_SH;

  logic signed [PROD_W-1:0] mul   [ORDER][ORDER];
  logic signed [PROD_W-1:0] gmul  [ORDER];
  logic signed [PROD_W-1:0] prod  [ORDER][ORDER];
  logic signed [PROD_W-1:0] gprod [ORDER];
  logic signed [ACC_W-1:0]  acc_next [ORDER];
  logic signed [ACC_W-1:0]  acc      [ORDER];
  op_e                      op2, op3;
  logic signed [STATE_W-1:0] y2, y3;

  // round half up, floor shift, clamp to 32 bits
  function automatic logic [STATE_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] shf;
    logic [SH_W-1:0]         sh;
    logic [SH_W-STATE_W:0]   hi;
    rnd = v + ACC_W'(2 ** (ROUND_SH - 1));
    shf = rnd >>> ROUND_SH;
    sh  = shf[SH_W-1:0];
    hi  = sh[SH_W-1:STATE_W-1];
    if (&hi || ~|hi) begin
      round_sat = sh[STATE_W-1:0];
    end else if (hi[SH_W-STATE_W]) begin
      round_sat = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      round_sat = {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

  always_comb begin
    for (int i = 0; i < ORDER; i++) begin
      for (int c = 0; c < ORDER; c++) begin
        mul[i][c] = $signed(cfg.a[i][c]) * $signed(x[c]);
      end
      gmul[i] = $signed(cfg.l[i]) * y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= mul;
      gprod <= gmul;
      op2   <= op;
      y2    <= y;
    end
  end

  always_comb begin
    for (int i = 0; i < ORDER; i++) begin
      acc_next[i] = ACC_W'(gprod[i]);
      for (int c = 0; c < ORDER; c++) begin
        acc_next[i] = acc_next[i] + ACC_W'(prod[i][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= acc_next;
      op3 <= op2;
      y3  <= y2;
    end
  end

  always_comb begin
    for (int i = 0; i < ORDER; i++) begin
      if (op3 == OP_INIT) begin
        nx[i] = (i == 0) ? y3 : '0;
      end else begin
        nx[i] = round_sat(acc[i]);
      end
    end
  end

endmodule
